// ===== design/wra_pkg.sv =====
// Shared types and constants for the windowed rate average block.
package wra_pkg;

	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;
	localparam int RATE_W  = 51;
	localparam int FRAC_SHIFT = 32;

	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [RATE_W-1:0]  rate_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_LOAD,
		ST_DIVIDE,
		ST_FINISH
	} wra_state_t;

endpackage

// ===== design/wra_if.sv =====
// Valid/ready channel interfaces for samples and rate results.
interface wra_sample_if;
	import wra_pkg::*;

	logic   valid;
	logic   ready;
	time_t  elapsed_time;
	count_t event_count;

	modport source (output valid, output elapsed_time, output event_count, input ready);
	modport sink (input valid, input elapsed_time, input event_count, output ready);
endinterface

interface wra_result_if;
	import wra_pkg::*;

	logic  valid;
	logic  ready;
	rate_t rate;
	logic  divide_error;

	modport source (output valid, output rate, output divide_error, input ready);
	modport sink (input valid, input rate, input divide_error, output ready);
endinterface

// ===== design/windowed_rate_average.sv =====
// Sliding-window average event rate: count sum over time sum, Q.32, via a serial divider.
// Each sample transaction is folded into a WINDOW-deep ring and running sums, then
// one restoring divider produces one quotient bit per cycle over QW = 48 + clog2(WINDOW)
// quotient bits (51 at WINDOW = 5). A new sample is taken only in idle, once the
// previous result has entered the output register. A zero time sum skips the divide and
// returns rate 0 with divide_error set. Rates above 2^51 - 1 saturate. The result
// sits in an output register, so the next sample is accepted while it waits.
module windowed_rate_average #(
	parameter int WINDOW = 5
) (
	input  logic clk,
	input  logic arst_n,
	wra_sample_if.sink   sample,
	wra_result_if.source result
);
	import wra_pkg::*;

	localparam int LW  = (WINDOW > 1) ? $clog2(WINDOW) : 0;
	localparam int SW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW  = $clog2(WINDOW + 1);
	localparam int TSW = TIME_W + LW;
	localparam int CSW = COUNT_W + LW;
	localparam int QW  = CSW + FRAC_SHIFT;
	localparam int QXW = (QW > RATE_W) ? QW : RATE_W;
	localparam int CW  = $clog2(QW);

	wra_state_t state_q, state_d;

	time_t          time_mem [WINDOW];
	count_t         count_mem [WINDOW];

	time_t          in_time_q;
	count_t         in_count_q;
	time_t          old_time_q;
	count_t         old_count_q;
	logic [TSW-1:0] time_sum_q;
	logic [CSW-1:0] count_sum_q;
	logic [SW-1:0]  slot_q;
	logic [FW-1:0]  fill_q;
	logic [TSW-1:0] rem_q;
	logic [QW-1:0]  quo_q;
	logic [CW-1:0]  step_q;
	logic           zero_q;
	logic           out_valid_q;
	rate_t          out_rate_q;
	logic           out_err_q;

	logic           full;
	logic [TSW:0]   rem_shift;
	logic [TSW:0]   rem_diff;
	logic           qbit;
	logic [QXW-1:0] quo_ext;
	rate_t          rate_sat;
	logic           out_free;

	assign full      = (fill_q == FW'(WINDOW));
	assign rem_shift = {rem_q, quo_q[QW-1]};
	assign rem_diff  = rem_shift - {1'b0, time_sum_q};
	assign qbit      = ~rem_diff[TSW];
	assign quo_ext   = QXW'(quo_q);
	assign rate_sat  = (quo_ext > QXW'({RATE_W{1'b1}})) ? {RATE_W{1'b1}} : quo_ext[RATE_W-1:0];
	assign out_free  = ~out_valid_q | result.ready;

	assign sample.ready        = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.rate         = out_rate_q;
	assign result.divide_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_LOAD;
			ST_LOAD: begin
				state_d = (time_sum_q == '0) ? ST_FINISH : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (step_q == CW'(QW - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ring storage
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			old_time_q  <= time_mem[slot_q];
			old_count_q <= count_mem[slot_q];
		end
		if (state_q == ST_UPDATE) begin
			time_mem[slot_q]  <= in_time_q;
			count_mem[slot_q] <= in_count_q;
		end
	end

	// window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_sum_q  <= '0;
			count_sum_q <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
		end else if (state_q == ST_UPDATE) begin
			time_sum_q  <= time_sum_q - (full ? TSW'(old_time_q) : '0) + TSW'(in_time_q);
			count_sum_q <= count_sum_q - (full ? CSW'(old_count_q) : '0) + CSW'(in_count_q);
			slot_q      <= (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// input capture and serial divider
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			in_time_q  <= sample.elapsed_time;
			in_count_q <= sample.event_count;
		end
		case (state_q)
			ST_LOAD: begin
				rem_q  <= '0;
				quo_q  <= {count_sum_q, {FRAC_SHIFT{1'b0}}};
				step_q <= '0;
				zero_q <= (time_sum_q == '0);
			end
			ST_DIVIDE: begin
				rem_q  <= qbit ? rem_diff[TSW-1:0] : rem_shift[TSW-1:0];
				quo_q  <= {quo_q[QW-2:0], qbit};
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_rate_q <= zero_q ? '0 : rate_sat;
			out_err_q  <= zero_q;
		end
	end

endmodule

// ===== test/wra_rate_checker.sv =====
// Checker for the windowed rate average: tracks the sample window and compares each rate result.
`timescale 1ns / 1ps

module wra_rate_checker #(
	parameter int WINDOW = 5
) (
	input  logic clk,
	input  logic arst_n,
	wra_sample_if sample,
	wra_result_if result,
	output int failures,
	output int pending
);
	import wra_pkg::*;

	typedef struct packed {
		rate_t rate;
		logic  divide_error;
	} rate_result_t;

	localparam logic [63:0] RATE_MAX = (64'd1 << RATE_W) - 64'd1;

	time_t        win_time [WINDOW];
	count_t       win_count [WINDOW];
	logic [63:0]  time_total;
	logic [63:0]  count_total;
	int           next_slot;
	int           held;
	rate_result_t expected_rates [$];
	rate_result_t oldest;
	int           fail_total = 0;
	int           in_flight = 0;

	assign failures = fail_total;
	assign pending  = in_flight;

	task automatic report(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_total++;
	endtask

	task automatic fold_sample(input time_t t, input count_t c);
		logic [63:0]  quotient;
		rate_result_t outcome;
		if (held >= WINDOW) begin
			time_total  -= win_time[next_slot];
			count_total -= win_count[next_slot];
		end else begin
			held++;
		end
		win_time[next_slot]  = t;
		win_count[next_slot] = c;
		time_total  += t;
		count_total += c;
		next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
		if (time_total == 0) begin
			outcome.rate         = '0;
			outcome.divide_error = 1'b1;
		end else begin
			quotient = (count_total << FRAC_SHIFT) / time_total;
			if (quotient > RATE_MAX) begin
				quotient = RATE_MAX;
			end
			outcome.rate         = quotient[RATE_W-1:0];
			outcome.divide_error = 1'b0;
		end
		expected_rates.push_back(outcome);
		in_flight++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_total  = '0;
			count_total = '0;
			next_slot   = 0;
			held        = 0;
			expected_rates.delete();
			in_flight = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_rates.size() == 0) begin
					report($sformatf("result transaction with none expected: rate %0h err %0b",
						result.rate, result.divide_error));
				end else begin
					oldest = expected_rates.pop_front();
					in_flight--;
					if (result.rate !== oldest.rate) begin
						report($sformatf("rate %0h, expected %0h", result.rate, oldest.rate));
					end
					if (result.divide_error !== oldest.divide_error) begin
						report($sformatf("divide_error %0b, expected %0b",
							result.divide_error, oldest.divide_error));
					end
				end
			end
			if (sample.valid && sample.ready) begin
				fold_sample(sample.elapsed_time, sample.event_count);
			end
		end
	end

endmodule

// ===== test/windowed_rate_average_tb.sv =====
// Testbench top for windowed_rate_average: clock, reset, sample stimulus and the verdict.
`timescale 1ns / 1ps

module windowed_rate_average_tb;
	import wra_pkg::*;

	localparam int WINDOW       = 5;
	localparam int IDLE_PCT     = 23;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 70;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   tx_idling    = 1'b1;
	bit   rx_idling    = 1'b1;
	bit   hold_request = 1'b0;
	int   fail_count;
	int   pending_count;

	wra_sample_if sample_ch ();
	wra_result_if result_ch ();

	windowed_rate_average #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	wra_rate_checker #(
		.WINDOW(WINDOW)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.failures (fail_count),
		.pending  (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("windowed_rate_average test failed");
		$finish;
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= !(rx_idling && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic offer_sample(input time_t t, input count_t c);
		@(negedge clk);
		while (tx_idling && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.elapsed_time <= t;
		sample_ch.event_count  <= c;
		@(posedge clk);
		while (!sample_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_count != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic random_run(input int n);
		time_t  t;
		count_t c;
		repeat (n) begin
			// zero-time burst empties the window time sum
			if ($urandom_range(39) == 0) begin
				repeat (WINDOW + $urandom_range(2)) begin
					offer_sample('0, count_t'($urandom));
				end
			end
			case ($urandom_range(9))
				0, 1: t = '0;
				2: t = time_t'($urandom_range(255, 1));
				3: t = '1;
				4: t = time_t'($urandom_range(65535));
				default: t = time_t'($urandom);
			endcase
			case ($urandom_range(5))
				0: c = '0;
				1: c = '1;
				2: c = count_t'($urandom_range(15));
				default: c = count_t'($urandom);
			endcase
			offer_sample(t, c);
		end
	endtask

	initial begin
		sample_ch.valid        = 1'b0;
		sample_ch.elapsed_time = '0;
		sample_ch.event_count  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// warm-up with zero time, then the largest rate the window allows
		offer_sample('0, '0);
		offer_sample('0, '1);
		offer_sample(32'd1, '1);
		offer_sample('0, '1);
		offer_sample('0, '1);
		offer_sample('0, '1);
		offer_sample('0, '1);
		// time 1 leaves the window: zero time sum with counts held
		offer_sample('0, '1);
		repeat (WINDOW) offer_sample('1, '1);
		repeat (WINDOW) offer_sample('1, '0);
		offer_sample(32'd1, '0);
		offer_sample(32'h8000_0000, 16'd1);
		offer_sample(32'h0000_FFFF, 16'h8000);
		offer_sample(32'h0001_0000, 16'h1234);

		random_run(300);

		hold_request = 1'b1;
		random_run(40);
		drain();

		tx_idling = 1'b0;
		rx_idling = 1'b0;
		random_run(200);
		tx_idling = 1'b1;
		rx_idling = 1'b1;

		random_run(140);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("windowed_rate_average test passed");
		end else begin
			$display("windowed_rate_average test failed");
		end
		$finish;
	end

endmodule
